// ----- sv/rpa_pkg.sv -----
// Shared types and constants for the reference-counted page allocator.
// Used by rpa_decode and refcounted_page_allocator; depends on nothing.
`default_nettype none

package rpa_pkg;

   localparam int NUM_PAGES_DEF  = 32768;
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int COUNT_BITS_DEF = 16;

   localparam int ADDR_W   = 40;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int RC_W     = 16;
   localparam int BASE_W   = 28;
   localparam int FIRST_W  = 28;
   localparam int LIMIT_W  = 29;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 29;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ADDREF = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PAGE = 2'd2;

   localparam logic [BASE_W-1:0]  BASE_PAGE_RST  = 28'd524288;
   localparam logic [FIRST_W-1:0] FIRST_PAGE_RST = 28'd524288;
   localparam logic [LIMIT_W-1:0] LIMIT_PAGE_RST = 29'd557056;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

`default_nettype wire

// ----- sv/refcounted_page_allocator.sv -----
// Top level of the reference-counted page allocator: FSM, count and link memories.
// Depends on rpa_pkg and rpa_decode.
//
// Each request is accepted in ST_IDLE, where the count and link memories are
// read into registers; ST_EXEC then, once the response register is free or
// being taken, writes them back and loads the response register. No new request
// is accepted until ST_EXEC completes. After reset a clearing pass zeroes the
// reference counts of all NUM_PAGES pages (32768 by default); no request is
// accepted during it, while configuration writes are taken at any time. The free
// list starts empty, so software frees every page once before allocating.
`default_nettype none

module refcounted_page_allocator
   import rpa_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [ADDR_W-1:0]     req_address,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ADDR_W-1:0]          rsp_page_address,
   output logic                       rsp_released,
   output logic [RC_W-1:0]            rsp_ref_count,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_BITS = $clog2(NUM_PAGES);
   localparam int LINK_W   = IDX_BITS + 1;
   localparam int OFF_BITS = $clog2(PAGE_BYTES);
   localparam int PG_W     = ADDR_W - OFF_BITS;
   localparam int CMP_W    = (PG_W >= 29) ? PG_W + 1 : 30;

   logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
   logic [LINK_W-1:0]     lnk_mem [NUM_PAGES];

   state_type state_ff, state_in;

   logic [IDX_BITS-1:0]   clr_ff, clr_in;
   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic                  empty_ff, empty_in;
   logic [KIND_W-1:0]     kind_ff;
   logic                  ok_ff;
   logic [IDX_BITS-1:0]   slot_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [LINK_W-1:0]     lnk_rd_ff;
   logic [BASE_W-1:0]     base_ff;
   logic [FIRST_W-1:0]    first_ff;
   logic [LIMIT_W-1:0]    limit_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                  rsp_rel_ff, rsp_rel_in;
   logic [RC_W-1:0]       rsp_rc_ff, rsp_rc_in;

   logic                  req_fire;
   logic                  exec_go;
   logic                  dec_ok;
   logic [IDX_BITS-1:0]   dec_slot;

   logic                  cnt_we;
   logic [IDX_BITS-1:0]   cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  lnk_we;
   logic [LINK_W-1:0]     lnk_wdata;
   logic [CMP_W-1:0]      alloc_page;

   rpa_decode #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_decode (
      .kind       (req_kind),
      .address    (req_address),
      .base_page  (base_ff),
      .first_page (first_ff),
      .limit_page (limit_ff),
      .ok         (dec_ok),
      .slot       (dec_slot)
   );

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_BITS'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      clr_in    = clr_ff;
      unique case (state_ff)
         ST_CLEAR: clr_in    = clr_ff + IDX_BITS'(1);
         ST_IDLE:  req_ready = 1'b1;
         ST_EXEC:  req_ready = 1'b0;
         default:  req_ready = 1'b0;
      endcase
   end

   always_comb begin
      cnt_we        = 1'b0;
      cnt_waddr     = slot_ff;
      cnt_wdata     = '0;
      lnk_we        = 1'b0;
      lnk_wdata     = {empty_ff, head_ff};
      head_in       = head_ff;
      empty_in      = empty_ff;
      alloc_page    = CMP_W'(base_ff) + CMP_W'(slot_ff);
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_rc_in     = rsp_rc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (state_ff == ST_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
      end

      if (exec_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_BAD;
         rsp_addr_in   = '0;
         rsp_rel_in    = 1'b0;
         rsp_rc_in     = '0;
         if (kind_ff == KIND_ALLOC) begin
            if (empty_ff) begin
               rsp_status_in = STATUS_OOM;
            end else begin
               cnt_we        = 1'b1;
               cnt_wdata     = COUNT_BITS'(1);
               head_in       = lnk_rd_ff[IDX_BITS-1:0];
               empty_in      = lnk_rd_ff[IDX_BITS];
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = ADDR_W'({alloc_page, {OFF_BITS{1'b0}}});
               rsp_rc_in     = RC_W'(1);
            end
         end else if (ok_ff) begin
            rsp_status_in = STATUS_OK;
            cnt_we        = 1'b1;
            if (kind_ff == KIND_FREE) begin
               if (cnt_rd_ff > COUNT_BITS'(1)) begin
                  cnt_wdata = cnt_rd_ff - COUNT_BITS'(1);
                  rsp_rc_in = RC_W'(32'(cnt_rd_ff - COUNT_BITS'(1)));
               end else begin
                  lnk_we     = 1'b1;
                  head_in    = slot_ff;
                  empty_in   = 1'b0;
                  rsp_rel_in = 1'b1;
               end
            end else begin
               if (cnt_rd_ff != '1) begin
                  cnt_wdata = cnt_rd_ff + COUNT_BITS'(1);
               end else begin
                  cnt_wdata = cnt_rd_ff;
               end
               rsp_rc_in = RC_W'(32'(cnt_wdata));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (req_fire) begin
         cnt_rd_ff <= cnt_mem[dec_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[slot_ff] <= lnk_wdata;
      end
      if (req_fire) begin
         lnk_rd_ff <= lnk_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_kind;
         ok_ff   <= dec_ok;
         slot_ff <= (req_kind == KIND_ALLOC) ? head_ff : dec_slot;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_rc_ff     <= rsp_rc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_PAGE_RST;
         first_ff     <= FIRST_PAGE_RST;
         limit_ff     <= LIMIT_PAGE_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BASE_PAGE:  base_ff  <= csr_data[BASE_W-1:0];
               CSR_FIRST_PAGE: first_ff <= csr_data[FIRST_W-1:0];
               CSR_LIMIT_PAGE: limit_ff <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_released     = rsp_rel_ff;
   assign rsp_ref_count    = rsp_rc_ff;

endmodule

`default_nettype wire

// ----- sv/rpa_decode.sv -----
// Request check for the page allocator: kind, alignment, managed window and store range.
// Depends on rpa_pkg.
`default_nettype none

module rpa_decode
   import rpa_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  wire logic [KIND_W-1:0]             kind,
   input  wire logic [ADDR_W-1:0]             address,
   input  wire logic [BASE_W-1:0]             base_page,
   input  wire logic [FIRST_W-1:0]            first_page,
   input  wire logic [LIMIT_W-1:0]            limit_page,
   output logic                               ok,
   output logic [$clog2(NUM_PAGES)-1:0]       slot
);

   localparam int OFF_BITS  = $clog2(PAGE_BYTES);
   localparam int IDX_BITS  = $clog2(NUM_PAGES);
   localparam int PG_W      = ADDR_W - OFF_BITS;
   localparam int CMP_W     = (PG_W >= 29) ? PG_W + 1 : 30;

   logic [CMP_W-1:0] page;
   logic [CMP_W-1:0] diff;
   logic             aligned;
   logic             in_window;
   logic             in_store;
   logic             kind_ok;

   always_comb begin
      page      = CMP_W'(address[ADDR_W-1:OFF_BITS]);
      diff      = page - CMP_W'(base_page);
      aligned   = (address[OFF_BITS-1:0] == '0);
      in_window = (page >= CMP_W'(first_page)) && (page < CMP_W'(limit_page));
      in_store  = (page >= CMP_W'(base_page)) && (diff < CMP_W'(NUM_PAGES));
      kind_ok   = (kind == KIND_FREE) || (kind == KIND_ADDREF);
      ok        = kind_ok && aligned && in_window && in_store;
      slot      = diff[IDX_BITS-1:0];
   end

endmodule

`default_nettype wire

// ----- tb/rpa_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the reference-counted page allocator: mirrors the free list, the
// reference counts and the page window, predicts each response and compares it.
// Depends on rpa_pkg; instantiated beside the allocator by tb.
module rpa_checker
   import rpa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [STATUS_W-1:0]   rsp_status,
   input  wire logic [ADDR_W-1:0]     rsp_page_address,
   input  wire logic                  rsp_released,
   input  wire logic [RC_W-1:0]       rsp_ref_count,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending
);

   localparam int SLOT_W      = $clog2(NUM_PAGES_DEF);
   localparam int OFFSET_BITS = $clog2(PAGE_BYTES_DEF);
   localparam bit [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   page_address;
      logic                released;
      logic [RC_W-1:0]     ref_count;
   } outcome_type;

   outcome_type              expected_q[$];
   bit [COUNT_BITS_DEF-1:0]  page_refs[NUM_PAGES_DEF];
   bit [SLOT_W-1:0]          link_next[NUM_PAGES_DEF];
   bit                       link_tail[NUM_PAGES_DEF];
   bit [SLOT_W-1:0]          free_head;
   bit                       free_empty;
   bit [BASE_W-1:0]          cfg_base;
   bit [FIRST_W-1:0]         cfg_first;
   bit [LIMIT_W-1:0]         cfg_limit;

   task automatic serve_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                                output outcome_type res);
      logic [63:0]       page;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] top;
      logic              mapped;
      res    = '0;
      page   = 64'(addr) >> OFFSET_BITS;
      mapped = (addr[OFFSET_BITS-1:0] == '0) &&
               page >= 64'(cfg_first) && page < 64'(cfg_limit) &&
               page >= 64'(cfg_base) && (page - 64'(cfg_base)) < 64'(NUM_PAGES_DEF);
      slot   = SLOT_W'(page - 64'(cfg_base));
      if (kind == KIND_ALLOC) begin
         if (free_empty) begin
            res.status = STATUS_OOM;
         end else begin
            top              = free_head;
            free_empty       = link_tail[top];
            free_head        = link_next[top];
            page_refs[top]   = 1;
            res.status       = STATUS_OK;
            res.page_address = ADDR_W'((64'(cfg_base) + 64'(top)) << OFFSET_BITS);
            res.ref_count    = 1;
         end
      end else if (kind == KIND_FREE && mapped) begin
         res.status = STATUS_OK;
         if (page_refs[slot] > 1) begin
            page_refs[slot] = page_refs[slot] - 1'b1;
            res.ref_count   = RC_W'(page_refs[slot]);
         end else begin
            page_refs[slot] = 0;
            link_next[slot] = free_head;
            link_tail[slot] = free_empty;
            free_head       = slot;
            free_empty      = 1'b0;
            res.released    = 1'b1;
         end
      end else if (kind == KIND_ADDREF && mapped) begin
         res.status = STATUS_OK;
         if (page_refs[slot] != COUNT_MAX) begin
            page_refs[slot] = page_refs[slot] + 1'b1;
         end
         res.ref_count = RC_W'(page_refs[slot]);
      end else begin
         res.status = STATUS_BAD;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      outcome_type want;
      outcome_type got;
      if (reset) begin
         expected_q.delete();
         for (int i = 0; i < NUM_PAGES_DEF; i++) begin
            page_refs[i] = 0;
            link_next[i] = 0;
            link_tail[i] = 1'b0;
         end
         free_head  = 0;
         free_empty = 1'b1;
         cfg_base   = BASE_PAGE_RST;
         cfg_first  = FIRST_PAGE_RST;
         cfg_limit  = LIMIT_PAGE_RST;
         pending   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_page_address, rsp_released, rsp_ref_count};
            if (expected_q.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("rpa_checker: unexpected response: status %0d addr %h",
                           got.status, got.page_address);
               end
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status || got.page_address !== want.page_address ||
                   got.released !== want.released || got.ref_count !== want.ref_count) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display("rpa_checker: mismatch at %0t", $realtime);
                     $display("rpa_checker: expected status %0d addr %h rel %0d count %0d",
                              want.status, want.page_address, want.released,
                              want.ref_count);
                     $display("rpa_checker: actual   status %0d addr %h rel %0d count %0d",
                              got.status, got.page_address, got.released, got.ref_count);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_PAGE:  cfg_base  = csr_data[BASE_W-1:0];
               CSR_FIRST_PAGE: cfg_first = csr_data[FIRST_W-1:0];
               CSR_LIMIT_PAGE: cfg_limit = csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            serve_request(req_kind, req_address, want);
            expected_q.push_back(want);
         end
         pending <= expected_q.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the page allocator testbench: clock, reset, request and register traffic,
// response back-pressure and the verdict. Depends on rpa_pkg, rpa_checker and the RTL.
module tb;
   import rpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int OFFSET_BITS    = $clog2(PAGE_BYTES_DEF);
   localparam logic [63:0] FIRST_PG = 64'(FIRST_PAGE_RST);
   localparam logic [63:0] LAST_PG  = 64'(LIMIT_PAGE_RST) - 1;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind    = KIND_ALLOC;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]     rsp_page_address;
   logic                  rsp_released;
   logic [RC_W-1:0]       rsp_ref_count;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_BASE_PAGE;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   refcounted_page_allocator i_dut (.*);

   rpa_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES - 1;
         hold_served <= hold_asked;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [ADDR_W-1:0] page_at(input logic [63:0] page);
      return ADDR_W'(page << OFFSET_BITS);
   endfunction

   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_window(input logic [BASE_W-1:0] base, input logic [FIRST_W-1:0] first,
                             input logic [LIMIT_W-1:0] limit);
      write_reg(CSR_BASE_PAGE, CSR_DATA_W'(base));
      write_reg(CSR_FIRST_PAGE, CSR_DATA_W'(first));
      write_reg(CSR_LIMIT_PAGE, CSR_DATA_W'(limit));
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Frees every page of the pool once, then runs a random mix in four idling modes.
   task automatic random_phase(input int n, input logic [63:0] lo, input int span);
      logic [ADDR_W-1:0] pool_addr;
      int                pick;
      send_idle_pct = 0;
      stall_pct    <= 0;
      for (int p = 0; p < span; p++) begin
         send_req(KIND_FREE, page_at(lo + p));
      end
      for (int q = 0; q < 4; q++) begin
         send_idle_pct = (q == 1) ? 75 : (q == 3) ? 6 : 0;
         stall_pct    <= (q == 2) ? 75 : (q == 3) ? 6 : 0;
         for (int i = 0; i < n / 4; i++) begin
            pool_addr = page_at(lo + $urandom_range(span - 1));
            pick      = $urandom_range(99);
            if (pick < 30) begin
               send_req(KIND_ALLOC, ADDR_W'({$urandom, $urandom}));
            end else if (pick < 60) begin
               send_req(KIND_FREE, pool_addr);
            end else if (pick < 80) begin
               send_req(KIND_ADDREF, pool_addr);
            end else if (pick < 88) begin
               send_req($urandom_range(1) ? KIND_FREE : KIND_ADDREF,
                        pool_addr | ADDR_W'($urandom_range(PAGE_BYTES_DEF - 1, 1)));
            end else if (pick < 94) begin
               send_req($urandom_range(1) ? KIND_FREE : KIND_ADDREF,
                        page_at(lo + $urandom_range(span + 3) - 2));
            end else begin
               send_req(KIND_W'($urandom), ADDR_W'({$urandom, $urandom}));
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list, malformed and out-of-window addresses, unknown kind.
      send_req(KIND_ALLOC, '0);
      send_req(KIND_W'(KIND_ADDREF + 1), page_at(FIRST_PG));
      send_req(KIND_FREE, page_at(FIRST_PG) + 1);
      send_req(KIND_FREE, page_at(64'(LIMIT_PAGE_RST)));
      send_req(KIND_ADDREF, page_at(FIRST_PG - 1));
      send_req(KIND_FREE, '1);
      send_req(KIND_ADDREF, '0);

      // Fill, reuse, drain to empty, then a repeated free of the same page.
      send_req(KIND_FREE, page_at(FIRST_PG));
      send_req(KIND_FREE, page_at(FIRST_PG + 1));
      send_req(KIND_FREE, page_at(LAST_PG));
      send_req(KIND_ALLOC, '0);
      send_req(KIND_ADDREF, page_at(LAST_PG));
      send_req(KIND_FREE, page_at(LAST_PG));
      send_req(KIND_FREE, page_at(LAST_PG));
      repeat (4) send_req(KIND_ALLOC, '0);
      send_req(KIND_ADDREF, page_at(FIRST_PG + 5));
      send_req(KIND_FREE, page_at(FIRST_PG + 5));
      send_req(KIND_FREE, page_at(FIRST_PG + 5));
      send_req(KIND_ALLOC, '1);

      // Raise one count several times and step it down once.
      repeat (16) send_req(KIND_ADDREF, page_at(FIRST_PG + 1));
      send_req(KIND_FREE, page_at(FIRST_PG + 1));

      hold_asked <= hold_asked + 1;
      random_phase(300, FIRST_PG + 16, 40);

      settle();
      set_window('0, '0, LIMIT_W'(NUM_PAGES_DEF));
      random_phase(240, 64'd0, 40);

      settle();
      set_window('1, '1, LIMIT_W'(1) << BASE_W);
      random_phase(140, 64'(BASE_W'('1)), 1);

      settle();
      set_window('1, '1, '0);
      random_phase(60, 64'(BASE_W'('1)), 1);

      settle();
      set_window(BASE_W'(600000), FIRST_W'(600003), LIMIT_W'(600000 + NUM_PAGES_DEF + 10));
      random_phase(240, 64'(600000 + NUM_PAGES_DEF - 20), 20);

      settle();
      set_window(BASE_PAGE_RST, FIRST_PAGE_RST, LIMIT_PAGE_RST);
      random_phase(120, FIRST_PG, 60);

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/rpa_pkg.sv
sv/rpa_decode.sv
sv/refcounted_page_allocator.sv
tb/rpa_checker.sv
tb/tb.sv
